/* design/assert_macros.svh */
// Assertion helpers shared by the edge reconstruction RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge outside reset
`define PPM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset
`define PPM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define PPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/ppm_er_pkg.sv */
// Shared types, widths and helper functions for the parabolic edge reconstruction.
// No dependencies; used by every module of the block.
package ppm_er_pkg;

  // Sample and coefficient formats
  localparam int unsigned SAMPLE_W   = 32;            // signed Q15.16
  localparam int unsigned FLAT_W     = 16;            // unsigned Q1.15
  localparam int unsigned FLAT_SHIFT = 15;
  localparam logic [FLAT_W-1:0] FLAT_ONE = FLAT_W'(1 << FLAT_SHIFT);

  // Internal widths
  localparam int unsigned DIFF_W = SAMPLE_W + 1;      // difference of two samples, slopes
  localparam int unsigned SDIF_W = SAMPLE_W + 2;      // difference of two slopes
  localparam int unsigned TW_W   = SAMPLE_W + 6;      // edge numerator in 1/12 units
  localparam int unsigned NUM_W  = SAMPLE_W + 4;      // clamped, offset numerator
  localparam int unsigned PROD_W = FLAT_W + 1 + DIFF_W;
  localparam int unsigned WIDE_W = SAMPLE_W + 3;      // 3c - 2e before saturation

  // Divide-by-twelve unit: radix-4 digit recurrence, split over a few stages
  localparam int unsigned DIV_DEN          = 12;
  localparam int unsigned REM_W            = 4;
  localparam int unsigned DIV_STAGES       = 3;
  localparam int unsigned DIGITS_PER_STAGE = NUM_W / 2 / DIV_STAGES;

  // Lanes and pipeline depth
  localparam int unsigned NUM_SLOPES  = 3;
  localparam int unsigned NUM_EDGES   = 2;
  localparam int unsigned EDGE_STAGES = 6 + DIV_STAGES;
  localparam int unsigned PIPE_DEPTH  = EDGE_STAGES + 2;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] cell_m2;
    logic signed [SAMPLE_W-1:0] cell_m1;
    logic signed [SAMPLE_W-1:0] cell_center;
    logic signed [SAMPLE_W-1:0] cell_p1;
    logic signed [SAMPLE_W-1:0] cell_p2;
    logic        [FLAT_W-1:0]   flatten;
  } ppm_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_edge;
    logic signed [SAMPLE_W-1:0] right_edge;
  } ppm_out_t;

  // What one edge lane hands to the limiter
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] edge_val;
    logic signed [SAMPLE_W-1:0] center;
  } lane_res_t;

  // One radix-4 step of division by twelve: returns {quotient digit, new remainder}
  function automatic logic [REM_W+1:0] div12_step(input logic [REM_W-1:0] rem,
                                                  input logic [1:0]       dig);
    logic [REM_W+1:0] val;
    logic [REM_W+1:0] sub;
    logic [1:0]       qd;
    val = {rem, dig};
    priority if (val >= (REM_W+2)'(3 * DIV_DEN)) begin
      qd  = 2'd3;
      sub = (REM_W+2)'(3 * DIV_DEN);
    end else if (val >= (REM_W+2)'(2 * DIV_DEN)) begin
      qd  = 2'd2;
      sub = (REM_W+2)'(2 * DIV_DEN);
    end else if (val >= (REM_W+2)'(DIV_DEN)) begin
      qd  = 2'd1;
      sub = (REM_W+2)'(DIV_DEN);
    end else begin
      qd  = 2'd0;
      sub = '0;
    end
    return {qd, REM_W'(val - sub)};
  endfunction

  // Clamp a wide signed value into the sample range
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [WIDE_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    priority if (v > WIDE_W'(SAMPLE_MAX)) begin
      r = SAMPLE_MAX;
    end else if (v < WIDE_W'(SAMPLE_MIN)) begin
      r = SAMPLE_MIN;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

/* design/ppm_er_slope_lane.sv */
// One slope lane: van Leer limited slope of the middle cell of three, held at twice its value.
// Depends on ppm_er_pkg.
module ppm_er_slope_lane (
  input  logic                                      clk_i,
  input  logic                                      en_i,
  input  logic signed [ppm_er_pkg::SAMPLE_W-1:0]    a_i,
  input  logic signed [ppm_er_pkg::SAMPLE_W-1:0]    b_i,
  input  logic signed [ppm_er_pkg::SAMPLE_W-1:0]    c_i,
  output logic signed [ppm_er_pkg::DIFF_W-1:0]      slope_o
);
  import ppm_er_pkg::*;

  logic signed [DIFF_W-1:0] lo, hi, cen;
  logic        [DIFF_W-1:0] abs_lo, abs_hi, abs_cen;
  logic        [DIFF_W+1:0] lim_lo, lim_hi, mag;
  logic                     agree;
  logic signed [DIFF_W-1:0] slope_d, slope_q;

  // One-sided and centered differences
  always_comb begin
    lo      = DIFF_W'(b_i) - DIFF_W'(a_i);
    hi      = DIFF_W'(c_i) - DIFF_W'(b_i);
    cen     = DIFF_W'(c_i) - DIFF_W'(a_i);
    abs_lo  = lo[DIFF_W-1]  ? DIFF_W'(-lo)  : DIFF_W'(lo);
    abs_hi  = hi[DIFF_W-1]  ? DIFF_W'(-hi)  : DIFF_W'(hi);
    abs_cen = cen[DIFF_W-1] ? DIFF_W'(-cen) : DIFF_W'(cen);
    agree   = ((lo > 0) && (hi > 0)) || ((lo < 0) && (hi < 0));
  end

  // Limit by four times each one-sided difference (twice the slope)
  always_comb begin
    lim_lo = {abs_lo, 2'b00};
    lim_hi = {abs_hi, 2'b00};
    mag    = {2'b00, abs_cen};
    if (lim_lo < mag) mag = lim_lo;
    if (lim_hi < mag) mag = lim_hi;
    if (!agree) begin
      slope_d = '0;
    end else if (cen[DIFF_W-1]) begin
      slope_d = -$signed(mag[DIFF_W-1:0]);
    end else begin
      slope_d = $signed(mag[DIFF_W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) slope_q <= slope_d;
  end

  assign slope_o = slope_q;

endmodule

/* design/ppm_er_edge_lane.sv */
// One edge lane: interpolates an edge between two cells, clamps it, and applies flattening.
// Depends on ppm_er_pkg; nine register stages including a three-stage divide by twelve.
module ppm_er_edge_lane (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic signed [ppm_er_pkg::SAMPLE_W-1:0]  x_i,
  input  logic signed [ppm_er_pkg::SAMPLE_W-1:0]  y_i,
  input  logic signed [ppm_er_pkg::SAMPLE_W-1:0]  c_i,
  input  logic signed [ppm_er_pkg::DIFF_W-1:0]    sx_i,
  input  logic signed [ppm_er_pkg::DIFF_W-1:0]    sy_i,
  input  logic        [ppm_er_pkg::FLAT_W-1:0]    flat_i,
  output ppm_er_pkg::lane_res_t                   res_o
);
  import ppm_er_pkg::*;

  // Stage 1: raw differences
  logic signed [DIFF_W-1:0]   delta1_q, xc1_q;
  logic signed [SDIF_W-1:0]   sdiff1_q;
  logic signed [SAMPLE_W-1:0] c1_q;
  logic        [FLAT_W-1:0]   f1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      delta1_q <= DIFF_W'(y_i) - DIFF_W'(x_i);
      xc1_q    <= DIFF_W'(x_i) - DIFF_W'(c_i);
      sdiff1_q <= SDIF_W'(sy_i) - SDIF_W'(sx_i);
      c1_q     <= c_i;
      f1_q     <= flat_i;
    end
  end

  // Stage 2: numerator in twelfths relative to x, clamp bounds
  logic signed [DIFF_W-1:0]   lo2, hi2;
  logic signed [TW_W-1:0]     tw2_d, lo12_d, hi12_d;
  logic signed [TW_W-1:0]     tw2_q, lo12_q, hi12_q;
  logic signed [DIFF_W-1:0]   blo2_q;
  logic signed [SAMPLE_W-1:0] c2_q;
  logic        [FLAT_W-1:0]   f2_q;

  always_comb begin
    lo2    = (delta1_q < 0) ? delta1_q : '0;
    hi2    = (delta1_q > 0) ? delta1_q : '0;
    tw2_d  = (TW_W'(delta1_q) <<< 2) + (TW_W'(delta1_q) <<< 1) - TW_W'(sdiff1_q)
             + TW_W'(DIV_DEN / 2);
    lo12_d = (TW_W'(lo2) <<< 3) + (TW_W'(lo2) <<< 2);
    hi12_d = (TW_W'(hi2) <<< 3) + (TW_W'(hi2) <<< 2) + TW_W'(DIV_DEN - 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tw2_q  <= tw2_d;
      lo12_q <= lo12_d;
      hi12_q <= hi12_d;
      blo2_q <= xc1_q + lo2;
      c2_q   <= c1_q;
      f2_q   <= f1_q;
    end
  end

  // Stage 3: clamp so the quotient lands between the two cells, offset to non-negative
  logic signed [TW_W-1:0]     tw_clamped;
  logic        [NUM_W-1:0]    num3_q;
  logic signed [DIFF_W-1:0]   blo3_q;
  logic signed [SAMPLE_W-1:0] c3_q;
  logic        [FLAT_W-1:0]   f3_q;

  always_comb begin
    priority if (tw2_q < lo12_q) begin
      tw_clamped = lo12_q;
    end else if (tw2_q > hi12_q) begin
      tw_clamped = hi12_q;
    end else begin
      tw_clamped = tw2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num3_q <= NUM_W'(tw_clamped - lo12_q);
      blo3_q <= blo2_q;
      c3_q   <= c2_q;
      f3_q   <= f2_q;
    end
  end

  // Divide by twelve, radix 4, MSB first; quotient digits shift in as dividend bits shift out
  logic        [NUM_W-1:0]    div_num_q [DIV_STAGES];
  logic        [REM_W-1:0]    div_rem_q [DIV_STAGES];
  logic signed [DIFF_W-1:0]   div_blo_q [DIV_STAGES];
  logic signed [SAMPLE_W-1:0] div_c_q   [DIV_STAGES];
  logic        [FLAT_W-1:0]   div_f_q   [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    logic        [NUM_W-1:0]    num_in, num_d;
    logic        [REM_W-1:0]    rem_in, rem_d;
    logic        [REM_W+1:0]    step;
    logic signed [DIFF_W-1:0]   blo_in;
    logic signed [SAMPLE_W-1:0] c_in;
    logic        [FLAT_W-1:0]   f_in;

    if (s == 0) begin : g_first
      assign num_in = num3_q;
      assign rem_in = '0;
      assign blo_in = blo3_q;
      assign c_in   = c3_q;
      assign f_in   = f3_q;
    end else begin : g_next
      assign num_in = div_num_q[s-1];
      assign rem_in = div_rem_q[s-1];
      assign blo_in = div_blo_q[s-1];
      assign c_in   = div_c_q[s-1];
      assign f_in   = div_f_q[s-1];
    end

    always_comb begin
      num_d = num_in;
      rem_d = rem_in;
      step  = '0;
      for (int k = 0; k < DIGITS_PER_STAGE; k++) begin
        step  = div12_step(rem_d, num_d[NUM_W-1 -: 2]);
        num_d = {num_d[NUM_W-3:0], step[REM_W+1:REM_W]};
        rem_d = step[REM_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        div_num_q[s] <= num_d;
        div_rem_q[s] <= rem_d;
        div_blo_q[s] <= blo_in;
        div_c_q[s]   <= c_in;
        div_f_q[s]   <= f_in;
      end
    end
  end

  // Stage 7: edge minus center; the quotient never exceeds the cell spacing
  logic signed [DIFF_W-1:0]   ediff7_q;
  logic signed [SAMPLE_W-1:0] c7_q;
  logic        [FLAT_W-1:0]   f7_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ediff7_q <= div_blo_q[DIV_STAGES-1]
                + $signed({1'b0, div_num_q[DIV_STAGES-1][SAMPLE_W-1:0]});
      c7_q     <= div_c_q[DIV_STAGES-1];
      f7_q     <= div_f_q[DIV_STAGES-1];
    end
  end

  // Stage 8: flattening product
  logic signed [PROD_W-1:0]   prod8_q;
  logic signed [SAMPLE_W-1:0] c8_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod8_q <= $signed({1'b0, f7_q}) * ediff7_q;
      c8_q    <= c7_q;
    end
  end

  // Stage 9: round to nearest (ties up) and add back the center
  logic signed [PROD_W-1:0] rnd, shifted;
  lane_res_t                res_q;

  always_comb begin
    rnd     = prod8_q + PROD_W'(1 << (FLAT_SHIFT - 1));
    shifted = rnd >>> FLAT_SHIFT;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.edge_val <= c8_q + $signed(shifted[SAMPLE_W-1:0]);
      res_q.center   <= c8_q;
    end
  end

  assign res_o = res_q;

endmodule

/* design/ppm_er_limiter.sv */
// Merging stage: combines both edges with the extremum and overshoot limiter, then saturates.
// Depends on ppm_er_pkg and assert_macros.svh; one register stage plus output logic.
`include "assert_macros.svh"

module ppm_er_limiter (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic                                    vld_i,
  input  logic signed [ppm_er_pkg::SAMPLE_W-1:0]  left_i,
  input  logic signed [ppm_er_pkg::SAMPLE_W-1:0]  right_i,
  input  logic signed [ppm_er_pkg::SAMPLE_W-1:0]  c_i,
  output ppm_er_pkg::ppm_out_t                    res_o
);
  import ppm_er_pkg::*;

  logic signed [DIFF_W-1:0]   dp_q, dm_q;
  logic signed [WIDE_W-1:0]   l3_q, r3_q;
  logic signed [SAMPLE_W-1:0] l_q, r_q, c_q;

  // Register stage: deviations from center and the overshoot replacements
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dp_q <= DIFF_W'(right_i) - DIFF_W'(c_i);
      dm_q <= DIFF_W'(c_i) - DIFF_W'(left_i);
      r3_q <= (WIDE_W'(c_i) <<< 1) + WIDE_W'(c_i) - (WIDE_W'(left_i) <<< 1);
      l3_q <= (WIDE_W'(c_i) <<< 1) + WIDE_W'(c_i) - (WIDE_W'(right_i) <<< 1);
      l_q  <= left_i;
      r_q  <= right_i;
      c_q  <= c_i;
    end
  end

  logic [DIFF_W-1:0] adp, adm;
  logic              extremum, over_r, over_l;
  logic              brackets;

  // Case detection
  always_comb begin
    adp      = dp_q[DIFF_W-1] ? DIFF_W'(-dp_q) : DIFF_W'(dp_q);
    adm      = dm_q[DIFF_W-1] ? DIFF_W'(-dm_q) : DIFF_W'(dm_q);
    extremum = (dp_q == '0) || (dm_q == '0) || (dp_q[DIFF_W-1] != dm_q[DIFF_W-1]);
    over_r   = {1'b0, adp} >= {adm, 1'b0};
    over_l   = {1'b0, adm} >= {adp, 1'b0};
  end

  // Limiter selection
  always_comb begin
    priority if (extremum) begin
      res_o.left_edge  = c_q;
      res_o.right_edge = c_q;
    end else if (over_r) begin
      res_o.left_edge  = l_q;
      res_o.right_edge = sat_sample(r3_q);
    end else if (over_l) begin
      res_o.left_edge  = sat_sample(l3_q);
      res_o.right_edge = r_q;
    end else begin
      // no overshoot: both edges pass through
      res_o.left_edge  = l_q;
      res_o.right_edge = r_q;
    end
  end

  // The center always lies between the limited edges
  assign brackets = ((res_o.left_edge <= c_q) && (c_q <= res_o.right_edge))
                 || ((res_o.left_edge >= c_q) && (c_q >= res_o.right_edge));

  `PPM_ASSERT_IMPL(a_center_between, clk_i, rst_ni, vld_i, brackets, "edges miss the center")

endmodule

/* design/ppm_edge_reconstruct_core.sv */
// Top level of the parabolic edge reconstruction: slope lanes, edge lanes, limiter, output skid.
// Depends on ppm_er_pkg, ppm_er_slope_lane, ppm_er_edge_lane, ppm_er_limiter, assert_macros.svh.
//
//   channel   signals                          payload             direction
//   in        in_valid_i / in_ready_o          in_req_i  (ppm_in_t)   into block
//   out       out_valid_o / out_ready_i        out_req_o (ppm_out_t)  out of block
//
// Accepts one request per cycle while in_ready_o is high; each result passes through
// the slope stage, the edge-lane stages, the limiter stage and the output register.
// The edge lanes hold the three-stage radix-4 divide by twelve and the flattening multiply.
// Reset clears the stage valid bits and the output and skid valid bits; no clearing pass.
// A stalled output parks one result in the skid; in_ready_o drops only while the skid is full.
`include "assert_macros.svh"

module ppm_edge_reconstruct_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ppm_er_pkg::ppm_in_t   in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ppm_er_pkg::ppm_out_t  out_req_o
);
  import ppm_er_pkg::*;

  logic                  en;
  logic [PIPE_DEPTH-1:0] vld_q;
  logic                  push;
  logic                  out_vld_q, skid_vld_q;
  ppm_out_t              out_q, skid_q, lim_res;

  assign en         = !skid_vld_q;
  assign in_ready_o = en;
  assign push       = en && vld_q[PIPE_DEPTH-1];

  // Stencil as an array so each lane picks its window by index
  logic signed [SAMPLE_W-1:0] cells [NUM_SLOPES+2];
  assign cells[0] = in_req_i.cell_m2;
  assign cells[1] = in_req_i.cell_m1;
  assign cells[2] = in_req_i.cell_center;
  assign cells[3] = in_req_i.cell_p1;
  assign cells[4] = in_req_i.cell_p2;

  // Stage 1: slope lanes, plus the middle cells and clamped flattening
  logic signed [DIFF_W-1:0]   slope [NUM_SLOPES];
  logic signed [SAMPLE_W-1:0] mid_q [NUM_SLOPES];
  logic        [FLAT_W-1:0]   flat_d, flat_q;

  for (genvar k = 0; k < NUM_SLOPES; k++) begin : g_slope
    ppm_er_slope_lane u_slope (
      .clk_i   (clk_i),
      .en_i    (en),
      .a_i     (cells[k]),
      .b_i     (cells[k+1]),
      .c_i     (cells[k+2]),
      .slope_o (slope[k])
    );
  end

  assign flat_d = (in_req_i.flatten > FLAT_ONE) ? FLAT_ONE : in_req_i.flatten;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NUM_SLOPES; k++) mid_q[k] <= cells[k+1];
      flat_q <= flat_d;
    end
  end

  // Edge lanes: left edge between m1 and center, right edge between center and p1
  lane_res_t lane_res [NUM_EDGES];

  for (genvar k = 0; k < NUM_EDGES; k++) begin : g_edge
    ppm_er_edge_lane u_edge (
      .clk_i  (clk_i),
      .en_i   (en),
      .x_i    (mid_q[k]),
      .y_i    (mid_q[k+1]),
      .c_i    (mid_q[1]),
      .sx_i   (slope[k]),
      .sy_i   (slope[k+1]),
      .flat_i (flat_q),
      .res_o  (lane_res[k])
    );
  end

  // Merge: limiter over both edges
  ppm_er_limiter u_limiter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (vld_q[PIPE_DEPTH-1]),
    .left_i  (lane_res[0].edge_val),
    .right_i (lane_res[1].edge_val),
    .c_i     (lane_res[0].center),
    .res_o   (lim_res)
  );

  // Control: stage valids, output register and skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (en) vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid_i};
      if (skid_vld_q) begin
        if (out_ready_i) skid_vld_q <= 1'b0;
      end else if (push && out_vld_q && !out_ready_i) begin
        skid_vld_q <= 1'b1;
      end
      if (push || skid_vld_q) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload: output register and skid
  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_ready_i) out_q <= skid_q;
    end else if (push) begin
      if (!out_vld_q || out_ready_i) begin
        out_q <= lim_res;
      end else begin
        skid_q <= lim_res;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_req_o   = out_q;

  // Check terms: output stall, result parked in the skid, lanes agree on the center
  logic out_stall, park, lane_ok;
  assign out_stall = out_vld_q && !out_ready_i;
  assign park      = push && out_stall;
  assign lane_ok   = !vld_q[PIPE_DEPTH-2] || (lane_res[0].center == lane_res[1].center);

  `PPM_ASSERT_IMPL(a_skid_needs_out, clk_i, rst_ni, skid_vld_q, out_vld_q, "skid without output")
  `PPM_ASSERT_IMPL(a_skid_cause, clk_i, rst_ni, $rose(skid_vld_q), $past(out_stall), "unstalled fill")
  `PPM_ASSERT_NEXT(a_stall_parks, clk_i, rst_ni, park, skid_vld_q, "stalled result lost")
  `PPM_ASSERT(a_lane_center, clk_i, rst_ni, lane_ok, "lane centers differ")

endmodule
